// ===== hdl/srta_pkg.sv =====
// ----------------------------------------------------------------------------
// srta_pkg
// Shared types and constants for the sorted region table allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package srta_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int GAP_SLOTS     = 3;
    localparam int OUT_GAPS      = 3;
    localparam int SHOWN_GAPS    = (GAP_SLOTS < OUT_GAPS) ? GAP_SLOTS : OUT_GAPS;
    localparam int OFF_W         = 15;
    localparam int END_W         = 16;
    localparam int CNT_W         = 3;
    localparam logic [OFF_W-1:0] BUFFER_END_RST = 15'd83;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_FIND,
        ST_A_WALK,
        ST_A_LINK1,
        ST_A_LINK2,
        ST_R_CHECK,
        ST_R_CONT,
        ST_G_START,
        ST_G_WALK,
        ST_G_TAIL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] length;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] prev;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] raddr;
        logic             reg_we;
        logic [IDX_W-1:0] reg_addr;
        logic [OFF_W-1:0] reg_start;
        logic [OFF_W-1:0] reg_length;
        logic             next_we;
        logic [IDX_W-1:0] next_addr;
        logic [IDX_W-1:0] next_data;
        logic             prev_we;
        logic [IDX_W-1:0] prev_addr;
        logic [IDX_W-1:0] prev_data;
        logic             used_set;
        logic             used_clr;
        logic [IDX_W-1:0] used_addr;
    } t_tbl_cmd;

    typedef struct packed {
        t_entry           rdata;
        logic             full;
        logic [IDX_W-1:0] free_idx;
    } t_tbl_stat;

    typedef struct packed {
        logic                          status;
        logic [OUT_GAPS-1:0][OFF_W-1:0] gap_off;
        logic [OUT_GAPS-1:0][END_W-1:0] gap_size;
        logic                          overflow;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/srta_table.sv =====
// ----------------------------------------------------------------------------
// srta_table
// Region entry storage with one registered read port and in-use flags.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_table
    import srta_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_tbl_cmd  i_cmd,
    output t_tbl_stat      o_stat
);

    logic [OFF_W-1:0] start_mem  [TABLE_ENTRIES];
    logic [OFF_W-1:0] length_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0] next_mem   [TABLE_ENTRIES];
    logic [IDX_W-1:0] prev_mem   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_used;
    t_entry           r_rdata;
    logic [IDX_W-1:0] w_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_we) begin
            start_mem[i_cmd.reg_addr]  <= i_cmd.reg_start;
            length_mem[i_cmd.reg_addr] <= i_cmd.reg_length;
        end
        if (i_cmd.next_we) begin
            next_mem[i_cmd.next_addr] <= i_cmd.next_data;
        end
        if (i_cmd.prev_we) begin
            prev_mem[i_cmd.prev_addr] <= i_cmd.prev_data;
        end
        r_rdata.start  <= start_mem[i_cmd.raddr];
        r_rdata.length <= length_mem[i_cmd.raddr];
        r_rdata.next   <= next_mem[i_cmd.raddr];
        r_rdata.prev   <= prev_mem[i_cmd.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd.used_set) begin
                r_used[i_cmd.used_addr] <= 1'b1;
            end
            if (i_cmd.used_clr) begin
                r_used[i_cmd.used_addr] <= 1'b0;
            end
        end
    end

    // lowest free entry, entry 0 is the null link
    always_comb begin
        w_free = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 1; k--) begin
            if (!r_used[k]) begin
                w_free = IDX_W'(k);
            end
        end
    end

    assign o_stat.rdata    = r_rdata;
    assign o_stat.free_idx = w_free;
    assign o_stat.full     = &r_used[TABLE_ENTRIES-1:1];

endmodule

`default_nettype wire

// ===== hdl/srta_alu.sv =====
// ----------------------------------------------------------------------------
// srta_alu
// Shared adder and subtract/compare unit used by the sequencer steps.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_alu
    import srta_pkg::*;
(
    input  wire logic [OFF_W-1:0] i_add_a,
    input  wire logic [OFF_W-1:0] i_add_b,
    input  wire logic [END_W-1:0] i_sub_a,
    input  wire logic [END_W-1:0] i_sub_b,
    output logic      [END_W-1:0] o_sum,
    output logic      [END_W-1:0] o_diff,
    output logic                  o_gt
);

    assign o_sum  = END_W'(i_add_a) + END_W'(i_add_b);
    assign o_diff = i_sub_a - i_sub_b;
    assign o_gt   = i_sub_a > i_sub_b;

endmodule

`default_nettype wire

// ===== hdl/srta_ctrl.sv =====
// ----------------------------------------------------------------------------
// srta_ctrl
// Sequencer: list walk for allocate and release, then gap report walk.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_ctrl
    import srta_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_func,
    input  wire logic [OFF_W-1:0] i_offset,
    input  wire logic [OFF_W-1:0] i_size,
    input  wire logic [OFF_W-1:0] i_buffer_end,
    input  wire logic             i_out_free,
    output logic                  o_done,
    output t_result               o_result,
    output t_tbl_cmd              o_cmd,
    input  wire t_tbl_stat        i_stat
);

    t_state r_state, n_state;
    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] r_rem, n_rem;
    logic [OFF_W-1:0] r_len, n_len;
    logic [END_W-1:0] r_end, n_end;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cl, n_cl;
    logic [IDX_W-1:0] r_nx, n_nx;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_status, n_status;
    logic [OUT_GAPS-1:0][OFF_W-1:0] r_goff, n_goff;
    logic [OUT_GAPS-1:0][END_W-1:0] r_gsize, n_gsize;

    logic [OFF_W-1:0] add_a, add_b;
    logic [END_W-1:0] sub_a, sub_b, w_sum, w_diff;
    logic             w_gt;
    t_entry           rd;

    assign rd = i_stat.rdata;

    srta_alu u_alu (
        .i_add_a (add_a),
        .i_add_b (add_b),
        .i_sub_a (sub_a),
        .i_sub_b (sub_b),
        .o_sum   (w_sum),
        .o_diff  (w_diff),
        .o_gt    (w_gt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_rem    <= n_rem;
        r_len    <= n_len;
        r_end    <= n_end;
        r_idx    <= n_idx;
        r_cl     <= n_cl;
        r_nx     <= n_nx;
        r_cur    <= n_cur;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_goff   <= n_goff;
        r_gsize  <= n_gsize;
    end

    always_comb begin
        n_state  = r_state;
        n_off    = r_off;
        n_rem    = r_rem;
        n_len    = r_len;
        n_end    = r_end;
        n_idx    = r_idx;
        n_cl     = r_cl;
        n_nx     = r_nx;
        n_cur    = r_cur;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_goff   = r_goff;
        n_gsize  = r_gsize;
        o_cmd    = '0;
        o_done   = 1'b0;
        add_a    = rd.start;
        add_b    = rd.length;
        sub_a    = END_W'(rd.start);
        sub_b    = r_end;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd.raddr = r_head;
                if (i_valid) begin
                    n_off    = i_offset;
                    n_rem    = i_size;
                    n_cnt    = '0;
                    n_status = 1'b0;
                    n_goff   = '0;
                    n_gsize  = '0;
                    n_cur    = r_head;
                    if (i_func == FUNC_ALLOC) begin
                        n_state = ST_A_FIND;
                    end else if (i_func == FUNC_RELEASE && r_head != '0) begin
                        n_state = ST_R_CHECK;
                    end else begin
                        n_state = ST_G_START;
                    end
                end
            end
            ST_A_FIND: begin
                if (i_stat.full) begin
                    n_status = 1'b1;
                    n_state  = ST_G_START;
                end else begin
                    n_idx           = i_stat.free_idx;
                    o_cmd.used_set  = 1'b1;
                    o_cmd.used_addr = i_stat.free_idx;
                    n_cl            = '0;
                    n_nx            = r_head;
                    o_cmd.raddr     = r_head;
                    n_state         = (r_head == '0) ? ST_A_LINK1 : ST_A_WALK;
                end
            end
            ST_A_WALK: begin
                if (rd.start > r_off) begin
                    n_state = ST_A_LINK1;
                end else begin
                    n_cl        = r_nx;
                    n_nx        = rd.next;
                    o_cmd.raddr = rd.next;
                    if (rd.next == '0) begin
                        n_state = ST_A_LINK1;
                    end
                end
            end
            ST_A_LINK1: begin
                o_cmd.reg_we     = 1'b1;
                o_cmd.reg_addr   = r_idx;
                o_cmd.reg_start  = r_off;
                o_cmd.reg_length = r_rem;
                o_cmd.next_we    = 1'b1;
                o_cmd.next_addr  = r_idx;
                o_cmd.next_data  = r_nx;
                o_cmd.prev_we    = 1'b1;
                o_cmd.prev_addr  = r_idx;
                o_cmd.prev_data  = r_cl;
                n_state          = ST_A_LINK2;
            end
            ST_A_LINK2: begin
                if (r_cl == '0) begin
                    n_head = r_idx;
                end else begin
                    o_cmd.next_we   = 1'b1;
                    o_cmd.next_addr = r_cl;
                    o_cmd.next_data = r_idx;
                end
                if (r_nx != '0) begin
                    o_cmd.prev_we   = 1'b1;
                    o_cmd.prev_addr = r_nx;
                    o_cmd.prev_data = r_idx;
                end
                n_state = ST_G_START;
            end
            ST_R_CHECK: begin
                if (r_off >= rd.start && END_W'(r_off) < w_sum) begin
                    if (r_cur == r_head) begin
                        n_head = rd.next;
                        if (rd.next != '0) begin
                            o_cmd.prev_we   = 1'b1;
                            o_cmd.prev_addr = rd.next;
                            o_cmd.prev_data = '0;
                        end
                    end else begin
                        o_cmd.next_we   = 1'b1;
                        o_cmd.next_addr = rd.prev;
                        o_cmd.next_data = rd.next;
                        if (rd.next != '0) begin
                            o_cmd.prev_we   = 1'b1;
                            o_cmd.prev_addr = rd.next;
                            o_cmd.prev_data = rd.prev;
                        end
                    end
                    o_cmd.used_clr  = 1'b1;
                    o_cmd.used_addr = r_cur;
                    n_len           = rd.length;
                    n_end           = w_sum;
                    if (rd.next != '0 && rd.length < r_rem) begin
                        o_cmd.raddr = rd.next;
                        n_cur       = rd.next;
                        n_state     = ST_R_CONT;
                    end else begin
                        n_state = ST_G_START;
                    end
                end else if (rd.next == '0) begin
                    n_state = ST_G_START;
                end else begin
                    o_cmd.raddr = rd.next;
                    n_cur       = rd.next;
                end
            end
            ST_R_CONT: begin
                sub_a = END_W'(r_rem);
                sub_b = END_W'(r_len);
                if (END_W'(rd.start) == r_end) begin
                    n_rem       = w_diff[OFF_W-1:0];
                    n_off       = rd.start;
                    o_cmd.raddr = r_cur;
                    n_state     = ST_R_CHECK;
                end else begin
                    n_state = ST_G_START;
                end
            end
            ST_G_START: begin
                n_end       = '0;
                n_cur       = r_head;
                o_cmd.raddr = r_head;
                n_state     = (r_head == '0) ? ST_G_TAIL : ST_G_WALK;
            end
            ST_G_WALK: begin
                if (w_gt) begin
                    if (r_cnt < CNT_W'(SHOWN_GAPS)) begin
                        n_goff[r_cnt[1:0]]  = r_end[OFF_W-1:0];
                        n_gsize[r_cnt[1:0]] = w_diff;
                    end
                    if (r_cnt <= CNT_W'(SHOWN_GAPS)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                n_end       = w_sum;
                n_cur       = rd.next;
                o_cmd.raddr = rd.next;
                if (rd.next == '0) begin
                    n_state = ST_G_TAIL;
                end
            end
            ST_G_TAIL: begin
                sub_a = END_W'(i_buffer_end) + 1'b1;
                sub_b = r_end;
                if (w_gt) begin
                    if (r_cnt < CNT_W'(SHOWN_GAPS)) begin
                        n_goff[r_cnt[1:0]]  = r_end[OFF_W-1:0];
                        n_gsize[r_cnt[1:0]] = w_diff;
                    end
                    if (r_cnt <= CNT_W'(SHOWN_GAPS)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_result.status   = r_status;
    assign o_result.gap_off  = r_goff;
    assign o_result.gap_size = r_gsize;
    assign o_result.overflow = (r_cnt > CNT_W'(SHOWN_GAPS));

endmodule

`default_nettype wire

// ===== hdl/sorted_region_table_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_region_table_allocator_unit
// Region table allocator with sorted linked list and free gap report.
// Timing: one table read per list step through one registered read port.
// Throughput: one item at a time, waiting while the output slot is busy; ready again
// the cycle after the result is loaded.
// Reset (i_rst_n low, synchronous): empty list, all entries free, buffer_end 83.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_region_table_allocator_unit
    import srta_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // func[1:0], offset[16:2], size[31:17]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, gap0_offset, gap0_size, gap1_offset, gap1_size,
    // gap2_offset, gap2_size, gaps_overflow, zero pad
    output logic [95:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [14:0] i_cfg_data
);

    logic [OFF_W-1:0] r_buffer_end;
    logic             r_tvalid;
    logic [95:0]      r_tdata;
    logic             w_done;
    logic             w_out_free;
    t_result          w_res;
    t_tbl_cmd         w_cmd;
    t_tbl_stat        w_stat;

    srta_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    srta_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tdata[1:0]),
        .i_offset     (s_axis_tdata[16:2]),
        .i_size       (s_axis_tdata[31:17]),
        .i_buffer_end (r_buffer_end),
        .i_out_free   (w_out_free),
        .o_done       (w_done),
        .o_result     (w_res),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    assign w_out_free = !r_tvalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_end <= BUFFER_END_RST;
            r_tvalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_buffer_end <= i_cfg_data;
            end
            if (w_done) begin
                r_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_tdata <= {1'b0, w_res.overflow,
                        w_res.gap_size[2], w_res.gap_off[2],
                        w_res.gap_size[1], w_res.gap_off[1],
                        w_res.gap_size[0], w_res.gap_off[0],
                        w_res.status};
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("result loaded while output slot busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item taken while sequencer busy");

    a_done_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

`default_nettype wire
